/* rtl/core/rfs_pkg.sv */
`default_nettype none

package rfs_pkg;

  localparam int ELEM_BITS     = 8;
  localparam int CNT_BITS      = 7;
  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SCAN    = 3'd3,
    OP_SKIP    = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_DISCARD = 3'd6,
    OP_SEARCH  = 3'd7
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // latch the input item
    logic exec;      // apply pointer update of the operation
    logic rd_issue;  // read storage at start + idx
    logic hit;       // record the match at start + idx
    logic step;      // advance idx
    logic load;      // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_burst;  // pop, peek or scan
    logic is_search;
    logic n_zero;
    logic idx_last;
    logic match;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/rfs_ram.sv */
`default_nettype none

module rfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rfs_ctrl.sv */
`default_nettype none

module rfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rfs_pkg::stat_t stat,
  output rfs_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_RD   = 6'b000100,
    S_SRD  = 6'b001000,
    S_SCMP = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_burst && !stat.n_zero) begin
          state_nxt = S_RD;
        end else if (stat.is_search && !stat.n_zero) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_SRD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.idx_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          // more elements of the burst still to read
          if (stat.is_burst && !stat.n_zero && !stat.idx_last) begin
            cmd.step  = 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rfs_dp.sv */
`default_nettype none

module rfs_dp #(
  parameter int DEPTH     = rfs_pkg::DEPTH_DEF,
  parameter int MAX_BURST = rfs_pkg::MAX_BURST_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rfs_pkg::cmd_t                     cmd,
  output rfs_pkg::stat_t                         stat,
  input  wire logic [2:0]                        in_op,
  input  wire logic [rfs_pkg::ELEM_BITS-1:0]     in_value,
  input  wire logic [rfs_pkg::CNT_BITS-1:0]      in_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [rfs_pkg::ELEM_BITS-1:0]     out_element,
  output logic                                   out_element_valid,
  output logic                                   out_last,
  output logic      [rfs_pkg::CNT_BITS-1:0]      out_moved,
  output logic      [$clog2(DEPTH):0]            out_used,
  output logic      [$clog2(DEPTH):0]            out_unused,
  output logic                                   out_found,
  output logic      [$clog2(DEPTH):0]            out_search_position
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CW    = rfs_pkg::CNT_BITS;
  localparam int EW    = rfs_pkg::ELEM_BITS;
  localparam int NW    = (PTR_W > CW) ? PTR_W : CW;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] mp_r, mp_nxt;
  logic [PTR_W-1:0] start_r;
  logic [NW-1:0]    n_r, idx_r;
  logic [CW-1:0]    moved_r;
  logic [EW-1:0]    value_r;
  rfs_pkg::op_t     op_r;
  logic             hit_r;
  logic             out_valid_r;

  logic [PTR_W-1:0] used_w;
  logic [NW-1:0]    used_n, cnt_n, n_calc;
  logic [CW-1:0]    cnt_c;
  logic [PTR_W-1:0] rd_ptr;
  logic [EW-1:0]    rdata;
  logic             full;
  logic             bursting;
  rfs_pkg::op_t     op_in;

  assign used_w   = wp_r - rp_r;
  assign used_n   = NW'(used_w);
  assign full     = used_w[PTR_W-1];
  assign cnt_c    = (in_count > CW'(MAX_BURST)) ? CW'(MAX_BURST) : in_count;
  assign cnt_n    = NW'(cnt_c);
  assign op_in    = rfs_pkg::op_t'(in_op);
  assign rd_ptr   = start_r + idx_r[PTR_W-1:0];

  // elements to deliver, drop or walk
  always_comb begin
    unique case (op_in)
      rfs_pkg::OP_POP, rfs_pkg::OP_PEEK, rfs_pkg::OP_SKIP: begin
        n_calc = (cnt_n < used_n) ? cnt_n : used_n;
      end
      rfs_pkg::OP_SCAN: begin
        n_calc = (cnt_n > used_n) ? '0 : cnt_n;
      end
      rfs_pkg::OP_SEARCH: begin
        n_calc = used_n;
      end
      default: begin
        n_calc = '0;
      end
    endcase
  end

  assign stat.is_burst  = (op_r == rfs_pkg::OP_POP) || (op_r == rfs_pkg::OP_PEEK) ||
                          (op_r == rfs_pkg::OP_SCAN);
  assign stat.is_search = (op_r == rfs_pkg::OP_SEARCH);
  assign stat.n_zero    = (n_r == '0);
  assign stat.idx_last  = (idx_r == n_r - NW'(1));
  assign stat.match     = (rdata == value_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign bursting = stat.is_burst && !stat.n_zero;

  rfs_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && (op_r == rfs_pkg::OP_PUSH) && !full),
    .waddr (wp_r[IDX_W-1:0]),
    .wdata (value_r),
    .re    (cmd.rd_issue),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    mp_nxt = mp_r;
    if (cmd.exec) begin
      unique case (op_r)
        rfs_pkg::OP_PUSH: begin
          if (!full) begin
            wp_nxt = wp_r + PTR_W'(1);
          end
        end
        rfs_pkg::OP_POP, rfs_pkg::OP_SKIP: begin
          rp_nxt = rp_r + PTR_W'(n_r);
        end
        rfs_pkg::OP_CLEAR: begin
          wp_nxt = '0;
          rp_nxt = '0;
        end
        rfs_pkg::OP_DISCARD: begin
          rp_nxt = wp_r;
        end
        rfs_pkg::OP_SEARCH: begin
          mp_nxt = rp_r;
        end
        default: begin
        end
      endcase
    end
    if (cmd.hit) begin
      mp_nxt = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      mp_r        <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= rfs_pkg::OP_PUSH;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      mp_r <= mp_nxt;
      if (cmd.accept) begin
        op_r <= op_in;
      end
      if (cmd.exec) begin
        hit_r <= 1'b0;
      end else if (cmd.hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r <= in_value;
      n_r     <= n_calc;
    end
    if (cmd.exec) begin
      start_r <= rp_r;
      idx_r   <= '0;
      if (op_r == rfs_pkg::OP_PUSH) begin
        moved_r <= CW'(!full);
      end else if (op_r == rfs_pkg::OP_SEARCH || op_r == rfs_pkg::OP_CLEAR ||
                   op_r == rfs_pkg::OP_DISCARD) begin
        moved_r <= '0;
      end else begin
        moved_r <= CW'(n_r);
      end
    end else if (cmd.step) begin
      idx_r <= idx_r + NW'(1);
    end
    if (cmd.load) begin
      out_element         <= bursting ? rdata : '0;
      out_element_valid   <= bursting;
      out_last            <= !bursting || stat.idx_last;
      out_moved           <= moved_r;
      out_used            <= used_w;
      out_unused          <= PTR_W'(DEPTH) - used_w;
      out_found           <= stat.is_search && hit_r;
      out_search_position <= mp_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_w <= PTR_W'(DEPTH))
    else $error("fill level above depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> stat.out_free)
    else $error("result register overwritten");

  a_push_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == rfs_pkg::OP_PUSH && !full) |=> (wp_r == $past(wp_r) + PTR_W'(1)))
    else $error("write pointer did not advance on push");

  a_hit_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit |-> (stat.is_search && stat.match))
    else $error("match recorded outside search");
`endif

endmodule

`default_nettype wire

/* rtl/core/ring_fifo_with_search_core.sv */
// Ring FIFO of DEPTH bytes with free-running pointers, burst read and byte
// search. One item is handled at a time. Push, skip, clear, discard and a pop,
// peek or scan that delivers nothing pass from one input transfer to the next
// through accept, pointer update and result load. Pop, peek and scan pass
// through accept and pointer update, then for each element read the storage
// RAM, whose output is registered, and then load the result register. Search
// reads and then compares each entry it visits, stopping at the first match
// or after the last entry, before the result load. A result waits in an output
// register, and the next item is taken once the previous item's last result
// sits there; a load waits while the receiver leaves that register unread.
`default_nettype none

module ring_fifo_with_search_core #(
  parameter int DEPTH     = rfs_pkg::DEPTH_DEF,
  parameter int MAX_BURST = rfs_pkg::MAX_BURST_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_op,
  input  wire logic [rfs_pkg::ELEM_BITS-1:0]  in_value,
  input  wire logic [rfs_pkg::CNT_BITS-1:0]   in_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rfs_pkg::ELEM_BITS-1:0]  out_element,
  output logic                                out_element_valid,
  output logic                                out_last,
  output logic      [rfs_pkg::CNT_BITS-1:0]   out_moved,
  output logic      [$clog2(DEPTH):0]         out_used,
  output logic      [$clog2(DEPTH):0]         out_unused,
  output logic                                out_found,
  output logic      [$clog2(DEPTH):0]         out_search_position
);

  rfs_pkg::cmd_t  cmd;
  rfs_pkg::stat_t stat;

  rfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfs_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_op               (in_op),
    .in_value            (in_value),
    .in_count            (in_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_element         (out_element),
    .out_element_valid   (out_element_valid),
    .out_last            (out_last),
    .out_moved           (out_moved),
    .out_used            (out_used),
    .out_unused          (out_unused),
    .out_found           (out_found),
    .out_search_position (out_search_position)
  );

endmodule

`default_nettype wire
